// ===== src/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the soil moisture conditioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smc_pkg;

  localparam int READING_W = 10;
  localparam int SUM_W     = 14;
  localparam int RSUM_W    = 16;
  localparam int LEVEL_W   = 11;
  localparam int DVD_W     = 17;
  localparam int DVS_W     = 10;
  localparam int NUM_W     = 18;

  localparam logic [READING_W-1:0] READING_MAX = 10'd1023;
  localparam logic [DVS_W-1:0]     SUM_DIV     = 10'd10;
  localparam logic [6:0]           PCT_FULL    = 7'd100;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SWEEP  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_MIN = 2'd0;
  localparam logic [1:0] CFG_MAX = 2'd1;
  localparam logic [1:0] CFG_AVG = 2'd2;
  localparam logic [1:0] CFG_RAW = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== src/soil_moisture_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// soil_moisture_conditioner_unit: per-sensor reading, moving average, scaling
// A sample item runs from accept to result through up to three passes of the shared
// divider plus the window memory accesses; in_ready returns in the cycle the result
// is registered. Sweep and other items finish in the accept cycle. A clear item with
// averaging on, and reset, start a window clearing pass over all SENSORS*WINDOW
// entries with in_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soil_moisture_conditioner_unit
  import smc_pkg::*;
#(
  parameter int SENSORS = 4,
  parameter int WINDOW  = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                kind,
  input  wire logic [1:0]                sensor,
  input  wire logic [SUM_W-1:0]          sample_sum,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     sensor_out,
  output logic signed [LEVEL_W-1:0]      level,
  output logic                           connected,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [READING_W-1:0]      cfg_data
);

  localparam int SENSOR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int RING_W   = $clog2(WINDOW);
  localparam int DEPTH    = SENSORS * WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int MW       = ADDR_W + 1;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIV10   = 4'd2;
  localparam logic [3:0] S_RDOLD   = 4'd3;
  localparam logic [3:0] S_UPD     = 4'd4;
  localparam logic [3:0] S_RDLAST  = 4'd5;
  localparam logic [3:0] S_CHKLAST = 4'd6;
  localparam logic [3:0] S_DIVAVG  = 4'd7;
  localparam logic [3:0] S_MAP     = 4'd8;
  localparam logic [3:0] S_DIVMAP  = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  // configuration
  logic [READING_W-1:0] moisture_min;
  logic [READING_W-1:0] moisture_max;
  logic                 averaging_enable;
  logic                 raw_mode;

  // control and state
  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [ADDR_W-1:0]    clr_cnt;
  logic [RING_W-1:0]    ring_idx;
  logic [RING_W-1:0]    ring_next;
  logic                 win_ready;
  logic [RSUM_W-1:0]    rsum [SENSORS];

  // working registers of the item in flight
  logic [1:0]           cur_sensor;
  logic [READING_W-1:0] reading;
  logic [READING_W-1:0] value;
  logic [RSUM_W-1:0]    avg_sum;
  logic signed [LEVEL_W-1:0] res_level;
  logic                 res_conn;

  // window memory
  logic [READING_W-1:0] mem [DEPTH];
  logic [READING_W-1:0] rd_data;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [READING_W-1:0] mem_wdata;
  logic                 mem_we;

  // datapath
  div_req_t             div_req;
  logic                 div_done;
  logic [DVD_W-1:0]     div_q;
  logic [READING_W-1:0] q_sat;
  logic [SENSOR_W-1:0]  sidx;
  logic [MW-1:0]        base_wide;
  logic [ADDR_W-1:0]    slot_addr;
  logic [ADDR_W-1:0]    last_addr;
  logic [RSUM_W-1:0]    rsum_new;
  logic signed [LEVEL_W-1:0] diff;
  logic signed [LEVEL_W-1:0] den;
  logic signed [NUM_W-1:0]   num;
  logic [DVD_W-1:0]     abs_num;
  logic [DVS_W-1:0]     abs_den;
  logic                 map_neg;
  logic                 accept;
  logic                 sensor_ok;
  logic                 out_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign sensor_ok = ({3'b000, sensor} < 5'(SENSORS));
  assign out_free  = !out_valid || out_ready;

  assign sidx      = SENSOR_W'(cur_sensor);
  assign base_wide = MW'(sidx) * MW'(WINDOW);
  assign slot_addr = ADDR_W'(base_wide + MW'(ring_idx));
  assign last_addr = ADDR_W'(base_wide + MW'(WINDOW - 1));
  assign rsum_new  = rsum[sidx] - RSUM_W'(rd_data) + RSUM_W'(reading);

  assign q_sat = (div_q[DVD_W-1:READING_W] != '0) ? READING_MAX : div_q[READING_W-1:0];

  // linear map operands
  assign diff    = $signed({1'b0, value}) - $signed({1'b0, moisture_min});
  assign den     = $signed({1'b0, moisture_max}) - $signed({1'b0, moisture_min});
  assign num     = NUM_W'(diff) * $signed(NUM_W'(PCT_FULL));
  assign map_neg = num[NUM_W-1] ^ den[LEVEL_W-1];
  assign abs_num = num[NUM_W-1] ? DVD_W'(-num) : DVD_W'(num);
  assign abs_den = den[LEVEL_W-1] ? DVS_W'(-den) : DVS_W'(den);

  assign ring_next = (ring_idx == RING_W'(WINDOW - 1)) ? '0 : ring_idx + 1'b1;

  smc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(sample_sum);
    div_req.divisor  = SUM_DIV;
    case (state)
      S_IDLE: begin
        div_req.start = accept && (kind == KIND_SAMPLE) && sensor_ok;
      end
      S_CHKLAST: begin
        div_req.start    = (rd_data != '0) && win_ready;
        div_req.dividend = DVD_W'(avg_sum);
        div_req.divisor  = DVS_W'(WINDOW);
      end
      S_MAP: begin
        div_req.start    = !raw_mode && (moisture_max != moisture_min) && !map_neg;
        div_req.dividend = abs_num;
        div_req.divisor  = abs_den;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = reading;
    mem_raddr = slot_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_UPD: begin
        mem_we = 1'b1;
      end
      S_RDLAST: begin
        mem_raddr = last_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_CLEAR && averaging_enable) begin
            state_next = S_CLEAR;
          end else if (kind == KIND_SAMPLE && sensor_ok) begin
            state_next = S_DIV10;
          end
        end
      end
      S_DIV10: begin
        if (div_done) begin
          if (q_sat < (moisture_min >> 1)) begin
            state_next = S_OUT;
          end else if (averaging_enable) begin
            state_next = S_RDOLD;
          end else begin
            state_next = S_MAP;
          end
        end
      end
      S_RDOLD:   state_next = S_UPD;
      S_UPD:     state_next = S_RDLAST;
      S_RDLAST:  state_next = S_CHKLAST;
      S_CHKLAST: state_next = div_req.start ? S_DIVAVG : S_MAP;
      S_DIVAVG: begin
        if (div_done) begin
          state_next = S_MAP;
        end
      end
      S_MAP:     state_next = div_req.start ? S_DIVMAP : S_OUT;
      S_DIVMAP: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      ring_idx         <= '0;
      win_ready        <= 1'b0;
      out_valid        <= 1'b0;
      moisture_min     <= '0;
      moisture_max     <= READING_MAX;
      averaging_enable <= 1'b0;
      raw_mode         <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        rsum[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN: moisture_min     <= cfg_data;
          CFG_MAX: moisture_max     <= cfg_data;
          CFG_AVG: averaging_enable <= cfg_data[0];
          CFG_RAW: raw_mode         <= cfg_data[0];
          default: ;
        endcase
      end

      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end

      if (accept && averaging_enable) begin
        if (kind == KIND_SWEEP) begin
          ring_idx <= ring_next;
          if (ring_next == RING_W'(WINDOW - 1)) begin
            win_ready <= 1'b1;
          end
        end else if (kind == KIND_CLEAR) begin
          ring_idx  <= '0;
          win_ready <= 1'b0;
          clr_cnt   <= '0;
          for (int i = 0; i < SENSORS; i++) begin
            rsum[i] <= '0;
          end
        end
      end

      // disconnected sensor restarts its running sum
      if (state == S_DIV10 && div_done && q_sat < (moisture_min >> 1)) begin
        rsum[sidx] <= '0;
      end
      if (state == S_UPD) begin
        rsum[sidx] <= rsum_new;
      end

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sensor <= sensor;
    end
    case (state)
      S_DIV10: begin
        reading   <= q_sat;
        value     <= q_sat;
        res_level <= '1;
        res_conn  <= 1'b0;
      end
      S_UPD: begin
        avg_sum <= rsum_new;
      end
      S_DIVAVG: begin
        value <= q_sat;
      end
      S_MAP: begin
        res_conn <= 1'b1;
        if (raw_mode) begin
          res_level <= $signed({1'b0, value});
        end else begin
          res_level <= '0;
        end
      end
      S_DIVMAP: begin
        res_level <= (div_q > DVD_W'(PCT_FULL)) ? LEVEL_W'(PCT_FULL) : LEVEL_W'(div_q);
      end
      default: ;
    endcase
    if (state == S_OUT && out_free) begin
      sensor_out <= cur_sensor;
      level      <= res_level;
      connected  <= res_conn;
    end
  end

endmodule

`default_nettype wire

// ===== src/smc_div.sv =====
// ----------------------------------------------------------------------------
// smc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smc_div
  import smc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DVD_W-1:0]    quo;
  logic [DVS_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic [DVS_W:0]      shifted;
  logic [DVS_W:0]      trial;
  logic                fits;

  assign shifted  = {rem, quo[DVD_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign fits     = (shifted >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[DVS_W-1:0];
      end else begin
        rem <= shifted[DVS_W-1:0];
      end
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_soil_moisture_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// tb_soil_moisture_conditioner_unit
// Self-checking bench for the soil moisture conditioner. Sample, sweep and
// clear items go in over valid/ready, and a local model of the reading,
// window average and percent scaling predicts every result. Results are
// checked in order while both sides idle at random. The run covers directed
// corner cases and random traffic under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_soil_moisture_conditioner_unit
  import smc_pkg::*;
();

  localparam int SENSORS       = 4;
  localparam int WINDOW        = 8;
  localparam int PCT_SPAN      = 100;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         sensor;
    logic [LEVEL_W-1:0] level;
    logic               conn;
  } moist_result_t;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic [1:0]                kind       = KIND_SAMPLE;
  logic [1:0]                sensor     = '0;
  logic [SUM_W-1:0]          sample_sum = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic [1:0]                sensor_out;
  logic signed [LEVEL_W-1:0] level;
  logic                      connected;
  logic                      cfg_we     = 1'b0;
  logic [1:0]                cfg_index  = CFG_MIN;
  logic [READING_W-1:0]      cfg_data   = '0;

  // model state
  logic [READING_W-1:0] min_r;
  logic [READING_W-1:0] max_r;
  logic                 avg_en;
  logic                 raw_en;
  logic [READING_W-1:0] history [SENSORS*WINDOW];
  logic [RSUM_W-1:0]    sensor_total [SENSORS];
  int                   ring;
  logic                 history_full;

  moist_result_t levels_due[$];

  logic gaps_on = 1'b1;
  int   n_samples;
  int   n_checked;
  int   n_disconnects;
  int   n_averaged;
  int   n_errors;
  int   quiet_cycles;
  int   stall_left;

  soil_moisture_conditioner_unit #(
    .SENSORS (SENSORS),
    .WINDOW  (WINDOW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .sensor     (sensor),
    .sample_sum (sample_sum),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sensor_out (sensor_out),
    .level      (level),
    .connected  (connected),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_history();
    for (int i = 0; i < SENSORS*WINDOW; i++) history[i] = '0;
    for (int i = 0; i < SENSORS; i++) sensor_total[i] = '0;
    ring         = 0;
    history_full = 1'b0;
  endtask

  function automatic int scale_percent(input int value);
    int lo;
    int hi;
    int m;
    lo = int'(min_r);
    hi = int'(max_r);
    if (hi == lo) return 0;
    m = ((value - lo) * PCT_SPAN) / (hi - lo);
    if (m < 0) m = 0;
    if (m > PCT_SPAN) m = PCT_SPAN;
    return m;
  endfunction

  // advances the model by one accepted item and queues the level it produces
  task automatic condition_item(input logic [1:0] k, input logic [1:0] s,
                                input logic [SUM_W-1:0] sum);
    int unsigned       rd;
    int                slot;
    int                lvl;
    logic [RSUM_W-1:0] acc;
    moist_result_t     r;
    case (k)
      KIND_SWEEP: begin
        if (avg_en) begin
          ring = (ring + 1) % WINDOW;
          if (ring == WINDOW - 1) history_full = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (avg_en) clear_history();
      end
      KIND_SAMPLE: begin
        n_samples++;
        rd = sum / SUM_DIV;
        if (rd > READING_MAX) rd = READING_MAX;
        r.sensor = s;
        if (rd < min_r / 2) begin
          sensor_total[s] = '0;
          r.level = '1;
          r.conn  = 1'b0;
          n_disconnects++;
        end else begin
          if (avg_en) begin
            slot = s * WINDOW + ring;
            acc = sensor_total[s] - history[slot];
            history[slot] = rd[READING_W-1:0];
            acc = acc + rd[RSUM_W-1:0];
            sensor_total[s] = acc;
            if (history[s*WINDOW + WINDOW - 1] != 0 && history_full) begin
              rd = acc / WINDOW;
              if (rd > READING_MAX) rd = READING_MAX;
              n_averaged++;
            end
          end
          if (raw_en) lvl = int'(rd);
          else lvl = scale_percent(int'(rd));
          r.level = lvl[LEVEL_W-1:0];
          r.conn  = 1'b1;
        end
        levels_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [READING_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_MIN: min_r  = data;
      CFG_MAX: max_r  = data;
      CFG_AVG: avg_en = data[0];
      CFG_RAW: raw_en = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [READING_W-1:0] lo, input logic [READING_W-1:0] hi,
                            input logic avg, input logic raw);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
    write_reg(CFG_AVG, {{(READING_W-1){1'b0}}, avg});
    write_reg(CFG_RAW, {{(READING_W-1){1'b0}}, raw});
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] k, input logic [1:0] s,
                           input logic [SUM_W-1:0] sum);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    sensor     <= s;
    sample_sum <= sum;
    do @(posedge clk); while (!in_ready);
    condition_item(k, s, sum);
  endtask

  // no-result items may still keep the block busy, so settle after the drain
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SUM_W-1:0] pick_sum();
    int lo;
    int hi;
    int t;
    lo = (min_r < max_r) ? int'(min_r) : int'(max_r);
    hi = (min_r < max_r) ? int'(max_r) : int'(min_r);
    t  = int'(min_r) / 2;
    case ($urandom_range(0, 9))
      0: return SUM_W'($urandom_range(((t > 2) ? t - 2 : 0) * 10, t * 10 + 29));
      1: return SUM_W'($urandom_range(10240, (1 << SUM_W) - 1));
      2: return SUM_W'($urandom_range(0, 10230));
      default: return SUM_W'($urandom_range(lo * 10, hi * 10 + 9));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(KIND_SAMPLE, 2'd0, 14'd0);
    send_item(KIND_SAMPLE, 2'd1, 14'd10230);
    send_item(KIND_SAMPLE, 2'd2, 14'd16383);
    send_item(KIND_SAMPLE, 2'd3, 14'd5115);
    // averaging is off: these leave the history alone
    send_item(KIND_UNUSED, 2'd3, 14'd16383);
    send_item(KIND_SWEEP, 2'd0, 14'd0);
    send_item(KIND_CLEAR, 2'd0, 14'd0);
    drain_and_settle();
  endtask

  task automatic test_bounds_and_disconnect();
    set_config(10'd1023, 10'd1023, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 2'd0, 14'd6000);
    send_item(KIND_SAMPLE, 2'd1, 14'd100);
    drain_and_settle();
    set_config(10'd800, 10'd200, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 2'd2, 14'd5000);
    drain_and_settle();
    set_config(10'd100, 10'd900, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 2'd3, 14'd7777);
    drain_and_settle();
  endtask

  task automatic test_window_average();
    set_config(10'd200, 10'd1023, 1'b1, 1'b1);
    repeat (WINDOW - 1) send_item(KIND_SWEEP, 2'd1, 14'd0);
    send_item(KIND_SAMPLE, 2'd0, 14'd10230);
    // disconnect clears the total but not the window, so the next sum wraps
    send_item(KIND_SAMPLE, 2'd0, 14'd0);
    send_item(KIND_SAMPLE, 2'd0, 14'd5000);
    send_item(KIND_CLEAR, 2'd2, 14'd1234);
    send_item(KIND_SAMPLE, 2'd0, 14'd5000);
    drain_and_settle();
  endtask

  task automatic run_random_phase(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_item(KIND_UNUSED, 2'($urandom), 14'($urandom));
      else if (pick < 5)
        send_item(KIND_CLEAR, 2'($urandom), 14'($urandom));
      else if (pick < 22)
        send_item(KIND_SWEEP, 2'($urandom), 14'($urandom));
      else
        send_item(KIND_SAMPLE, 2'($urandom), pick_sum());
    end
    drain_and_settle();
  endtask

  task automatic test_random_traffic();
    set_config(10'd0, 10'd1023, 1'b1, 1'b0);
    run_random_phase(150);
    set_config(10'd1023, 10'd0, 1'b1, 1'b0);
    run_random_phase(150);
    set_config(10'($urandom), 10'($urandom), 1'b1, 1'b0);
    run_random_phase(150);
    set_config(10'($urandom), 10'($urandom), 1'b0, 1'($urandom));
    run_random_phase(150);
    set_config(10'($urandom_range(0, 400)), 10'($urandom_range(600, 1023)), 1'b1, 1'b1);
    run_random_phase(150);
    gaps_on = 1'b0;
    set_config(10'($urandom_range(0, 500)), 10'($urandom_range(300, 1023)), 1'b1,
               1'($urandom));
    run_random_phase(150);
  endtask

  // result checker and output stalls
  always @(posedge clk) begin
    moist_result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (levels_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result at %0t: sensor %0d level %0d connected %0d",
                     $realtime, sensor_out, level, connected);
        end else begin
          want = levels_due.pop_front();
          if (sensor_out !== want.sensor || level !== want.level ||
              connected !== want.conn) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("mismatch at %0t: sensor %0d/%0d level %0d/%0d connected %0d/%0d",
                       $realtime, want.sensor, sensor_out, $signed(want.level), level,
                       want.conn, connected);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tb_soil_moisture_conditioner_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    n_samples     = 0;
    n_checked     = 0;
    n_disconnects = 0;
    n_averaged    = 0;
    n_errors      = 0;
    quiet_cycles  = 0;
    min_r  = 10'd0;
    max_r  = READING_MAX;
    avg_en = 1'b0;
    raw_en = 1'b0;
    clear_history();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // reset starts a window clearing pass
    drain_and_settle();
    test_reset_defaults();
    test_bounds_and_disconnect();
    test_window_average();
    test_random_traffic();
    $display("run covered %0d sample items, %0d results checked", n_samples, n_checked);
    $display("%0d disconnected readings, %0d window averages", n_disconnects, n_averaged);
    if (n_errors == 0 && levels_due.size() == 0) begin
      $display("tb_soil_moisture_conditioner_unit: PASS");
    end else begin
      $display("tb_soil_moisture_conditioner_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smc_pkg.sv
src/smc_div.sv
src/soil_moisture_conditioner_unit.sv
dv/tb_soil_moisture_conditioner_unit.sv
